// ===== hw/rtl/gdi_pkg.sv =====
// Package for the Gregorian date information block.
// Holds widths, divider selection codes and the calendar lookup functions.
// No dependencies.
`default_nettype none

package gdi_pkg;

  // Field widths.
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int WD_W    = 3;
  localparam int DOY_W   = 9;
  localparam int DME_W   = 6;

  // Shared reciprocal multiplier: operand, constant and quotient widths.
  localparam int OPND_W = 15;
  localparam int RCP_W  = 16;
  localparam int PROD_W = OPND_W + RCP_W;
  localparam int QUOT_W = 14;

  // Divide by 25 is exact for operands below 4096 with this reciprocal.
  localparam int                 SHIFT_25 = 17;
  localparam logic [RCP_W-1:0]   RCP_25   = 16'd5243;
  // Divide by 7 is exact for operands below 32768 with this reciprocal.
  localparam int                 SHIFT_7  = 18;
  localparam logic [RCP_W-1:0]   RCP_7    = 16'd37450;

  // Divisor selection for the shared multiplier.
  localparam logic DIV_BY_25 = 1'b0;
  localparam logic DIV_BY_7  = 1'b1;

  // Calendar months.
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // Days in a month; zero for a month number outside January to December.
  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] len;
    begin
      unique case (month)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
        4'd2:                                        len = leap ? 5'd29 : 5'd28;
        default:                                     len = 5'd0;
      endcase
      return len;
    end
  endfunction

  // Days before the first of the month in a common year.
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
    logic [DOY_W-1:0] cnt;
    begin
      unique case (month)
        4'd2:    cnt = 9'd31;
        4'd3:    cnt = 9'd59;
        4'd4:    cnt = 9'd90;
        4'd5:    cnt = 9'd120;
        4'd6:    cnt = 9'd151;
        4'd7:    cnt = 9'd181;
        4'd8:    cnt = 9'd212;
        4'd9:    cnt = 9'd243;
        4'd10:   cnt = 9'd273;
        4'd11:   cnt = 9'd304;
        4'd12:   cnt = 9'd334;
        default: cnt = 9'd0;
      endcase
      return cnt;
    end
  endfunction

  // Month term of the weekday sum: floor(31 * m / 12), where m is the
  // month counted from March, with January and February (and month zero)
  // taken as the tail of the previous year.
  function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] month);
    logic [5:0] term;
    begin
      unique case (month)
        4'd0:    term = 6'd25;
        4'd1:    term = 6'd28;
        4'd2:    term = 6'd31;
        4'd3:    term = 6'd2;
        4'd4:    term = 6'd5;
        4'd5:    term = 6'd7;
        4'd6:    term = 6'd10;
        4'd7:    term = 6'd12;
        4'd8:    term = 6'd15;
        4'd9:    term = 6'd18;
        4'd10:   term = 6'd20;
        4'd11:   term = 6'd23;
        4'd12:   term = 6'd25;
        4'd13:   term = 6'd28;
        4'd14:   term = 6'd31;
        default: term = 6'd33;
      endcase
      return term;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gdi_recip_mul.sv =====
// Shared constant divider: multiply by a reciprocal, register, shift.
// Uses gdi_pkg for widths, reciprocals and the divisor codes.
`default_nettype none

module gdi_recip_mul (
  input  wire logic                       clk,
  input  wire logic                       start,
  input  wire logic                       sel,
  input  wire logic [gdi_pkg::OPND_W-1:0] operand,
  output logic      [gdi_pkg::QUOT_W-1:0] quot
);

  logic [gdi_pkg::PROD_W-1:0] prod_r;
  logic                       sel_r;
  logic [gdi_pkg::RCP_W-1:0]  rcp;

  // Pick the reciprocal for the requested divisor.
  always_comb begin
    rcp = (sel == gdi_pkg::DIV_BY_7) ? gdi_pkg::RCP_7 : gdi_pkg::RCP_25;
  end

  // One multiply per start, product held until the next start.
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= gdi_pkg::PROD_W'(operand) * gdi_pkg::PROD_W'(rcp);
      sel_r  <= sel;
    end
  end

  // The shift depends on the divisor that produced the product.
  always_comb begin
    if (sel_r == gdi_pkg::DIV_BY_7) begin
      quot = gdi_pkg::QUOT_W'(prod_r >> gdi_pkg::SHIFT_7);
    end else begin
      quot = gdi_pkg::QUOT_W'(prod_r >> gdi_pkg::SHIFT_25);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gregorian_date_info.sv =====
// Gregorian date information: leap year, weekday and day counts for a date.
// Depends on gdi_pkg and on gdi_recip_mul, the shared constant divider.
//
// Usage:
//   The input channel (in_valid, in_ready) takes one word of year, month
//   and day. The result channel (out_valid, out_ready) returns one word per
//   input word: leap flag, weekday (0 is Sunday), week flags, day of year
//   and the days left in the week, month and year.
//   One multiplier, used as a divider by 25 or by 7, is stepped by a small
//   sequencer: year / 100 for the leap test, shifted year / 100 for the
//   weekday sum, then the sum modulo 7. A result word is registered as the
//   last step ends. in_ready is high only while the sequencer is idle, so
//   no new word is taken until the last one has been through every step.
//   If the receiver stalls with a result still held, the sequencer waits in
//   its last step and takes no new word until the held result is taken.
//   Reset (rst_n low at a clock edge) returns the sequencer to idle and
//   drops out_valid; no clearing pass is needed.
`default_nettype none

module gregorian_date_info (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [gdi_pkg::YEAR_W-1:0]   in_year,
  input  wire logic [gdi_pkg::MONTH_W-1:0]  in_month,
  input  wire logic [gdi_pkg::DAY_W-1:0]    in_day,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_leap_flag,
  output logic      [gdi_pkg::WD_W-1:0]     out_weekday,
  output logic                              out_end_of_week,
  output logic                              out_weekend_flag,
  output logic                              out_business_day,
  output logic      [gdi_pkg::WD_W-1:0]     out_days_to_week_end,
  output logic      [gdi_pkg::DOY_W-1:0]    out_day_of_year,
  output logic signed [gdi_pkg::DME_W-1:0]  out_days_to_month_end,
  output logic      [gdi_pkg::DOY_W-1:0]    out_days_to_year_end
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LEAP = 3'd1;
  localparam logic [2:0] ST_YEAR = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_MOD  = 3'd4;

  localparam int SUM_W = 16;

  logic [2:0] state_r, state_nxt;

  // Captured date and intermediate values.
  logic [gdi_pkg::YEAR_W-1:0]  year_r;
  logic [gdi_pkg::MONTH_W-1:0] month_r;
  logic [gdi_pkg::DAY_W-1:0]   day_r;
  logic                        leap_r;
  logic [11:0]                 q4_r;
  logic [gdi_pkg::OPND_W-1:0]  sum_r;

  // Result register.
  logic                         out_valid_r;
  logic                         leap_out_r;
  logic [gdi_pkg::WD_W-1:0]     wd_r;
  logic [gdi_pkg::DOY_W-1:0]    doy_r;
  logic [gdi_pkg::DME_W-1:0]    dme_r;
  logic [gdi_pkg::DOY_W-1:0]    dye_r;

  // Shared divider.
  logic                        mul_start;
  logic                        mul_sel;
  logic [gdi_pkg::OPND_W-1:0]  mul_opnd;
  logic [gdi_pkg::QUOT_W-1:0]  mul_quot;

  logic in_fire;
  logic out_load;

  gdi_recip_mul u_recip_mul (
    .clk     (clk),
    .start   (mul_start),
    .sel     (mul_sel),
    .operand (mul_opnd),
    .quot    (mul_quot)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == ST_MOD) && (!out_valid_r || out_ready);

  // January, February and month zero count in the previous year.
  logic                          shift_back;
  logic signed [SUM_W-1:0]       y_s;
  logic                          y_neg;
  logic [11:0]                   yq4;

  always_comb begin
    shift_back = (month_r <= gdi_pkg::MON_FEB);
    y_s        = $signed({2'b00, year_r}) - $signed({15'd0, shift_back});
    y_neg      = (year_r == '0) && shift_back;
    // Truncating division of minus one gives zero.
    yq4        = y_neg ? 12'd0 : y_s[13:2];
  end

  // Leap test from year / 4 divided by 25.
  logic [gdi_pkg::QUOT_W-1:0] rem25;
  logic                       div4, div100, div400, leap_calc;

  always_comb begin
    rem25     = gdi_pkg::QUOT_W'(year_r[13:2])
                - gdi_pkg::QUOT_W'(mul_quot * gdi_pkg::QUOT_W'(25));
    div4      = (year_r[1:0] == 2'b00);
    div100    = div4 && (rem25 == '0);
    div400    = div100 && (mul_quot[1:0] == 2'b00);
    leap_calc = div400 || (div4 && !div100);
  end

  // Weekday sum: day + y + y/4 - y/100 + y/400 + month term.
  logic [SUM_W-1:0] sum_calc;

  always_comb begin
    sum_calc = SUM_W'(day_r) + SUM_W'(y_s) + SUM_W'(q4_r)
               - SUM_W'(mul_quot) + SUM_W'(mul_quot >> 2)
               + SUM_W'(gdi_pkg::month_term(month_r));
  end

  // Multiplier operand per step.
  always_comb begin
    mul_start = 1'b0;
    mul_sel   = gdi_pkg::DIV_BY_25;
    mul_opnd  = '0;
    unique case (state_r)
      ST_LEAP: begin
        mul_start = 1'b1;
        mul_opnd  = gdi_pkg::OPND_W'(year_r[13:2]);
      end
      ST_YEAR: begin
        mul_start = 1'b1;
        mul_opnd  = gdi_pkg::OPND_W'(yq4);
      end
      ST_SUM: begin
        mul_start = 1'b1;
        mul_sel   = gdi_pkg::DIV_BY_7;
        mul_opnd  = sum_calc[gdi_pkg::OPND_W-1:0];
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // Final step: remainder mod 7 and the day counts.
  logic [gdi_pkg::OPND_W-1:0]  rem7;
  logic [gdi_pkg::WD_W-1:0]    wd_calc;
  logic [gdi_pkg::DAY_W-1:0]   mlen;
  logic                        day_ok;
  logic [gdi_pkg::DOY_W-1:0]   doy_calc;
  logic [gdi_pkg::DOY_W-1:0]   ylen;

  always_comb begin
    rem7     = sum_r - gdi_pkg::OPND_W'(mul_quot * gdi_pkg::QUOT_W'(7));
    wd_calc  = rem7[gdi_pkg::WD_W-1:0];
    mlen     = gdi_pkg::month_len(leap_r, month_r);
    day_ok   = (day_r != '0) && (day_r <= mlen);
    doy_calc = '0;
    if (day_ok) begin
      doy_calc = gdi_pkg::days_before(month_r) + gdi_pkg::DOY_W'(day_r)
                 + gdi_pkg::DOY_W'(leap_r && (month_r > gdi_pkg::MON_FEB));
    end
    ylen     = leap_r ? 9'd366 : 9'd365;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_LEAP;
      ST_LEAP: state_nxt = ST_YEAR;
      ST_YEAR: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_MOD;
      ST_MOD:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      year_r  <= in_year;
      month_r <= in_month;
      day_r   <= in_day;
    end
    if (state_r == ST_YEAR) begin
      leap_r <= leap_calc;
      q4_r   <= yq4;
    end
    if (state_r == ST_SUM) begin
      sum_r <= sum_calc[gdi_pkg::OPND_W-1:0];
    end
    if (out_load) begin
      leap_out_r <= leap_r;
      wd_r       <= wd_calc;
      doy_r      <= doy_calc;
      dme_r      <= gdi_pkg::DME_W'({1'b0, mlen} - {1'b0, day_r});
      dye_r      <= ylen - doy_calc;
    end
  end

  // Result word.
  assign out_valid             = out_valid_r;
  assign out_leap_flag         = leap_out_r;
  assign out_weekday           = wd_r;
  assign out_end_of_week       = (wd_r == 3'd6);
  assign out_weekend_flag      = (wd_r == 3'd5) || (wd_r == 3'd6);
  assign out_business_day      = !((wd_r == 3'd5) || (wd_r == 3'd6));
  assign out_days_to_week_end  = 3'd6 - wd_r;
  assign out_day_of_year       = doy_r;
  assign out_days_to_month_end = $signed(dme_r);
  assign out_days_to_year_end  = dye_r;

endmodule

`default_nettype wire

// ===== bench/gregorian_date_info_tb.sv =====
// Self-checking testbench for gregorian_date_info: dates in, calendar facts out.
// Depends on gdi_pkg for field widths and on the gregorian_date_info RTL.
// A short table of directed dates is followed by random dates, with random stalls.

module gregorian_date_info_tb;

  localparam int N_RANDOM       = 650;
  localparam int N_DIRECTED     = 25;
  localparam int HOLD_OFF_AT    = 200;
  localparam int HOLD_OFF_LEN   = 200;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int FRIDAY         = 5;
  localparam int SATURDAY       = 6;

  // Calendar facts of one date, at the widths of the result channel.
  typedef struct {
    logic                             leap_flag;
    logic [gdi_pkg::WD_W-1:0]         weekday;
    logic                             end_of_week;
    logic                             weekend_flag;
    logic                             business_day;
    logic [gdi_pkg::WD_W-1:0]         days_to_week_end;
    logic [gdi_pkg::DOY_W-1:0]        day_of_year;
    logic signed [gdi_pkg::DME_W-1:0] days_to_month_end;
    logic [gdi_pkg::DOY_W-1:0]        days_to_year_end;
  } date_facts_t;

  // One directed date; facts are used only where typed is set.
  typedef struct {
    logic [gdi_pkg::YEAR_W-1:0]  year;
    logic [gdi_pkg::MONTH_W-1:0] month;
    logic [gdi_pkg::DAY_W-1:0]   day;
    bit                          typed;
    date_facts_t                 facts;
  } date_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [gdi_pkg::YEAR_W-1:0] in_year = '0;
  logic [gdi_pkg::MONTH_W-1:0] in_month = '0;
  logic [gdi_pkg::DAY_W-1:0] in_day = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_leap_flag;
  logic [gdi_pkg::WD_W-1:0] out_weekday;
  logic out_end_of_week;
  logic out_weekend_flag;
  logic out_business_day;
  logic [gdi_pkg::WD_W-1:0] out_days_to_week_end;
  logic [gdi_pkg::DOY_W-1:0] out_day_of_year;
  logic signed [gdi_pkg::DME_W-1:0] out_days_to_month_end;
  logic [gdi_pkg::DOY_W-1:0] out_days_to_year_end;

  date_facts_t pending_facts[$];
  date_facts_t oldest_facts;
  int mismatches = 0;
  int dates_sent = 0;
  int idle_cycles = 0;

  // Directed dates: well-known days typed in, the rest left to the predictor.
  date_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{2000, 1, 1, 1'b1, '{1, 6, 1, 1, 0, 0, 1, 30, 365}},
    '{2000, 12, 31, 1'b1, '{1, 0, 0, 0, 1, 6, 366, 0, 0}},
    '{0, 1, 1, 1'b1, '{1, 0, 0, 0, 1, 6, 1, 30, 365}},
    '{2001, 0, 0, 1'b1, '{0, 4, 0, 0, 1, 2, 0, 0, 365}},
    '{2001, 2, 29, 1'b1, '{0, 4, 0, 0, 1, 2, 0, -1, 365}},
    '{16383, 15, 31, 1'b1, '{0, 0, 0, 0, 1, 6, 0, -31, 365}},
    '{9999, 12, 31, 1'b0, '{default: 0}},
    '{1, 1, 1, 1'b0, '{default: 0}},
    '{1, 2, 28, 1'b0, '{default: 0}},
    '{2000, 2, 29, 1'b0, '{default: 0}},
    '{1900, 2, 29, 1'b0, '{default: 0}},
    '{1900, 3, 1, 1'b0, '{default: 0}},
    '{2024, 13, 5, 1'b0, '{default: 0}},
    '{2024, 14, 10, 1'b0, '{default: 0}},
    '{0, 0, 31, 1'b0, '{default: 0}},
    '{0, 2, 29, 1'b0, '{default: 0}},
    '{16383, 12, 31, 1'b0, '{default: 0}},
    '{8191, 6, 15, 1'b0, '{default: 0}},
    '{2023, 4, 31, 1'b0, '{default: 0}},
    '{2023, 11, 0, 1'b0, '{default: 0}},
    '{2400, 12, 31, 1'b0, '{default: 0}},
    '{2100, 2, 29, 1'b0, '{default: 0}},
    '{10922, 7, 21, 1'b0, '{default: 0}},
    '{5461, 10, 10, 1'b0, '{default: 0}},
    '{4, 2, 29, 1'b0, '{default: 0}}
  };

  gregorian_date_info u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_year               (in_year),
    .in_month              (in_month),
    .in_day                (in_day),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_leap_flag         (out_leap_flag),
    .out_weekday           (out_weekday),
    .out_end_of_week       (out_end_of_week),
    .out_weekend_flag      (out_weekend_flag),
    .out_business_day      (out_business_day),
    .out_days_to_week_end  (out_days_to_week_end),
    .out_day_of_year       (out_day_of_year),
    .out_days_to_month_end (out_days_to_month_end),
    .out_days_to_year_end  (out_days_to_year_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gregorian leap rule on the raw year, so year zero counts as a leap year.
  function automatic bit is_leap_year(input int yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  // Days in a month; zero for anything outside January to December.
  function automatic int days_in_month(input bit leap, input int mon);
    case (mon)
      1, 3, 5, 7, 8, 10, 12:  return 31;
      4, 6, 9, 11:            return 30;
      int'(gdi_pkg::MON_FEB): return leap ? 29 : 28;
      default:                return 0;
    endcase
  endfunction

  // Calendar facts of one date. The weekday uses the shifted-month sum with
  // divisions that truncate toward zero, as for year zero in January.
  function automatic date_facts_t predict_date_facts(
      input logic [gdi_pkg::YEAR_W-1:0] yr,
      input logic [gdi_pkg::MONTH_W-1:0] mon,
      input logic [gdi_pkg::DAY_W-1:0] dy);
    date_facts_t f;
    bit leap;
    int mlen, ylen, shift, sy, sm, total, wd, doy, dme, dye, i;
    leap = is_leap_year(int'(yr));
    mlen = days_in_month(leap, int'(mon));
    ylen = leap ? 366 : 365;
    shift = (14 - int'(mon)) / 12;
    sy = int'(yr) - shift;
    sm = int'(mon) + 12 * shift - 2;
    total = int'(dy) + sy + sy / 4 - sy / 100 + sy / 400 + (31 * sm) / 12;
    wd = total % 7;
    if (wd < 0) begin
      wd = wd + 7;
    end
    doy = 0;
    if (int'(dy) >= 1 && int'(dy) <= mlen) begin
      doy = int'(dy);
      for (i = 1; i < int'(mon); i++) begin
        doy = doy + days_in_month(leap, i);
      end
    end
    dme = mlen - int'(dy);
    dye = ylen - doy;
    f.leap_flag = leap;
    f.weekday = wd[gdi_pkg::WD_W-1:0];
    f.end_of_week = (wd == SATURDAY);
    f.weekend_flag = (wd == FRIDAY) || (wd == SATURDAY);
    f.business_day = !f.weekend_flag;
    f.days_to_week_end = 3'(SATURDAY - wd);
    f.day_of_year = doy[gdi_pkg::DOY_W-1:0];
    f.days_to_month_end = dme[gdi_pkg::DME_W-1:0];
    f.days_to_year_end = dye[gdi_pkg::DOY_W-1:0];
    return f;
  endfunction

  // Cycles to idle before a word; some windows run with no idling at all.
  function automatic int pick_wait(input int idx);
    if (idx % 150 >= 100) begin
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic check_field(input string name, input integer want, input integer got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Offer one date word and record its expected facts once it is taken.
  task automatic send_date(input logic [gdi_pkg::YEAR_W-1:0] yr,
                           input logic [gdi_pkg::MONTH_W-1:0] mon,
                           input logic [gdi_pkg::DAY_W-1:0] dy, input bit typed,
                           input date_facts_t typed_facts);
    int gap;
    gap = pick_wait(dates_sent);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_year <= yr;
    in_month <= mon;
    in_day <= dy;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_facts.push_back(typed ? typed_facts : predict_date_facts(yr, mon, dy));
    dates_sent++;
  endtask

  // Result side: random stalls, plus one long hold-off that backs up the block.
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = (taken == HOLD_OFF_AT) ? HOLD_OFF_LEN : pick_wait(taken);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  // Compare each result word with the oldest pending date.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_facts.size() == 0) begin
        $error("result word with no date pending");
        mismatches++;
      end else begin
        oldest_facts = pending_facts.pop_front();
        check_field("leap_flag", oldest_facts.leap_flag, out_leap_flag);
        check_field("weekday", oldest_facts.weekday, out_weekday);
        check_field("end_of_week", oldest_facts.end_of_week, out_end_of_week);
        check_field("weekend_flag", oldest_facts.weekend_flag, out_weekend_flag);
        check_field("business_day", oldest_facts.business_day, out_business_day);
        check_field("days_to_week_end", oldest_facts.days_to_week_end,
                    out_days_to_week_end);
        check_field("day_of_year", oldest_facts.day_of_year, out_day_of_year);
        check_field("days_to_month_end", oldest_facts.days_to_month_end,
                    out_days_to_month_end);
        check_field("days_to_year_end", oldest_facts.days_to_year_end,
                    out_days_to_year_end);
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("gregorian_date_info verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset, directed dates, random dates, then drain and report.
  initial begin : date_source
    logic [gdi_pkg::YEAR_W-1:0] yr;
    logic [gdi_pkg::MONTH_W-1:0] mon;
    logic [gdi_pkg::DAY_W-1:0] dy;
    bit [31:0] draw;
    int mlen;
    int n;
    date_facts_t unused_facts;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < N_DIRECTED; n++) begin
      send_date(directed_rows[n].year, directed_rows[n].month, directed_rows[n].day,
                directed_rows[n].typed, directed_rows[n].facts);
    end

    // Mostly real dates in the nominal era; the rest spans every field value.
    for (n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 7) == 0) begin
        draw = $urandom_range(0, 163) * 100;
      end else if ($urandom_range(0, 9) < 7) begin
        draw = $urandom_range(1, 9999);
      end else begin
        draw = $urandom_range(0, 16383);
      end
      yr = draw[gdi_pkg::YEAR_W-1:0];
      draw = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(0, 15);
      mon = draw[gdi_pkg::MONTH_W-1:0];
      mlen = days_in_month(is_leap_year(int'(yr)), int'(mon));
      if (mlen > 0 && $urandom_range(0, 99) < 85) begin
        draw = $urandom_range(1, mlen);
      end else begin
        draw = $urandom_range(0, 31);
      end
      dy = draw[gdi_pkg::DAY_W-1:0];
      send_date(yr, mon, dy, 1'b0, unused_facts);
    end
    in_valid <= 1'b0;

    while (pending_facts.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("gregorian_date_info verification clean");
    end else begin
      $display("gregorian_date_info verification failed");
    end
    $finish;
  end

endmodule
